>>> rtl/ats_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants for the autoscaled trace segment block
// Beat payloads, sequencer states, register codes and datapath widths.
// ----------------------------------------------------------------------------
package ats_pkg;

   localparam int SAMPLE_W  = 24;  // Q15.8 sample
   localparam int EXT_W     = 25;  // sample plus one bit for min/max widening
   localparam int CFG_W     = 12;  // configuration register width
   localparam int COORD_W   = 13;  // pixel coordinate width
   localparam int CSR_IDX_W = 2;   // register index width
   localparam int PROD_Y_W  = 37;  // (v - min) * height
   localparam int DIV_NUM_W = 38;  // divider dividend width
   localparam int DIV_DEN_W = 26;  // divider divisor width
   localparam int DIV_Q_W   = 13;  // quotient bits, one per step
   localparam int DIV_STEP_W = 4;  // step counter width
   localparam int WIDEN_LSB = 256; // 1.0 in Q15.8

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_series;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_end;
      logic               final_segment;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numer;
      logic [DIV_DEN_W-1:0] denom;
   } div_req_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X    = 2'd0,
      CSR_ORIGIN_Y    = 2'd1,
      CSR_PLOT_WIDTH  = 2'd2,
      CSR_PLOT_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_ADJ,
      ST_PT_RD,
      ST_PT_SUB,
      ST_DIVX,
      ST_MULY,
      ST_YSTART,
      ST_DIVY,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/ats_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ats_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ats_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_div: serial restoring divider
// One quotient bit per cycle; quotient must fit DIV_Q_W bits.
// ----------------------------------------------------------------------------
module ats_div (
   input  logic                            clock,
   input  logic                            reset,
   input  ats_pkg::div_req_type            req,
   output logic                            done,
   output logic [ats_pkg::DIV_Q_W-1:0]     quot
);

   localparam int NW = ats_pkg::DIV_NUM_W;
   localparam int DW = ats_pkg::DIV_DEN_W;
   localparam int QW = ats_pkg::DIV_Q_W;
   localparam int SW = ats_pkg::DIV_STEP_W;

   logic          busy_ff, busy_in;
   logic [SW-1:0] step_ff, step_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] lo_ff, lo_in;
   logic [DW-1:0] den_ff, den_in;

   logic [DW:0] rem_sh;
   logic [DW:0] diff;
   logic        ge;
   logic        last_step;

   assign rem_sh    = {rem_ff, lo_ff[QW-1]};
   assign diff      = rem_sh - {1'b0, den_ff};
   assign ge        = rem_sh >= {1'b0, den_ff};
   assign last_step = step_ff == SW'(QW - 1);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = DW'(req.numer[NW-1:QW]);
         lo_in   = req.numer[QW-1:0];
         den_in  = req.denom;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
         lo_in   = {lo_ff[QW-2:0], ge};
         step_in = step_ff + SW'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
   end

   assign done = busy_ff && last_step;
   assign quot = lo_ff;

endmodule

>>> rtl/autoscaled_trace_segments_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoscaled_trace_segments_top: min/max autoscaled line plot segment source
// Buffers a sample series, scans its range, maps each sample to a pixel
// point and emits one line segment per pair of neighboring points.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | carries
//  --------+--------------------------------+-----------+--------------------------
//  req     | req_valid, req_stall, req_data | in        | one sample per beat
//  rsp     | rsp_valid, rsp_stall, rsp_data | out       | one line segment per beat
//  csr     | csr_we, csr_index, csr_wdata   | in        | register write, no wait
//
//  Loading takes one cycle per sample beat; req_stall is low only while loading.
//  At the end mark the block scans the store, then maps each point in steps:
//  RAM read, subtract, a pass through the shared serial divider for x,
//  multiply, a second pass through that divider for y, and emit.
//  A full output register that stays stalled holds the sequencer in its emit
//  step; otherwise the next point proceeds while the segment waits.
//  Synchronous active-high reset; no clearing pass, the store is read only
//  where written in the current series.
// ----------------------------------------------------------------------------
module autoscaled_trace_segments_top #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ats_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ats_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [ats_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ats_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int XPW = AW + ats_pkg::CFG_W;
   localparam int SW = ats_pkg::SAMPLE_W;
   localparam int EW = ats_pkg::EXT_W;
   localparam int FW = ats_pkg::CFG_W;
   localparam int PW = ats_pkg::COORD_W;
   localparam int YW = ats_pkg::PROD_Y_W;
   localparam int NW = ats_pkg::DIV_NUM_W;
   localparam int DW = ats_pkg::DIV_DEN_W;
   localparam int QW = ats_pkg::DIV_Q_W;

   // sequencer and counters
   ats_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;         // samples stored so far
   logic [CW-1:0]      ser_cnt_ff, ser_cnt_in; // samples in the closed series
   logic [AW-1:0]      idx_ff, idx_in;

   // configuration
   logic [FW-1:0] ox_ff, ox_in, oy_ff, oy_in, pw_ff, pw_in, ph_ff, ph_in;

   // range and per-point datapath
   logic signed [EW-1:0] min_ff, min_in, max_ff, max_in;
   logic [EW-1:0]        dv_ff, dv_in;       // v - min
   logic [QW-1:0]        qx_ff, qx_in;       // x quotient
   logic [YW-1:0]        prod_ff, prod_in;   // (v - min) * height
   logic [PW-1:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   ats_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // shared pieces
   logic [SW-1:0]        ram_rdata;
   logic                 ram_we;
   logic signed [EW-1:0] rd_ext;
   logic [EW-1:0]        den;
   logic [XPW-1:0]       x_prod;
   logic [YW-1:0]        y_prod;
   logic [PW-1:0]        pt_x, pt_y;
   ats_pkg::div_req_type div_req;
   logic                 div_done;
   logic [QW-1:0]        div_quot;

   logic          load_beat;
   logic          has_room;
   logic [CW-1:0] ser_cnt_new;
   logic          scan_last;
   logic          pt_last;
   logic          out_free;

   assign load_beat   = (state_ff == ats_pkg::ST_LOAD) && req_valid;
   assign has_room    = cnt_ff < CW'(MAX_SAMPLES);
   assign ser_cnt_new = has_room ? cnt_ff + CW'(1) : cnt_ff;
   assign ram_we      = load_beat && has_room;
   assign scan_last   = CW'(idx_ff) == ser_cnt_ff - CW'(1);
   assign pt_last     = scan_last;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign rd_ext = {ram_rdata[SW-1], ram_rdata};
   assign den    = max_ff - min_ff;
   assign x_prod = XPW'(idx_ff) * XPW'(pw_ff);
   assign y_prod = YW'(dv_ff) * YW'(ph_ff);
   assign pt_x   = PW'(qx_ff) + PW'(ox_ff);
   assign pt_y   = PW'(ph_ff) - PW'(div_quot) + PW'(oy_ff);

   ats_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (req_data.sample),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   ats_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // divider operand select: x = i*W/count, y = (2*num + den) / (2*den)
   always_comb begin
      div_req = '0;
      if (state_ff == ats_pkg::ST_PT_SUB) begin
         div_req.start = 1'b1;
         div_req.numer = NW'(x_prod);
         div_req.denom = DW'(ser_cnt_ff);
      end else if (state_ff == ats_pkg::ST_YSTART) begin
         div_req.start = 1'b1;
         div_req.numer = {prod_ff, 1'b0} + NW'(den);
         div_req.denom = {den, 1'b0};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ats_pkg::ST_LOAD: begin
            if (load_beat && req_data.end_of_series && ser_cnt_new >= CW'(2)) begin
               state_in = ats_pkg::ST_SCAN_RD;
            end
         end
         ats_pkg::ST_SCAN_RD:  state_in = ats_pkg::ST_SCAN_CMP;
         ats_pkg::ST_SCAN_CMP: state_in = scan_last ? ats_pkg::ST_ADJ : ats_pkg::ST_SCAN_RD;
         ats_pkg::ST_ADJ:      state_in = ats_pkg::ST_PT_RD;
         ats_pkg::ST_PT_RD:    state_in = ats_pkg::ST_PT_SUB;
         ats_pkg::ST_PT_SUB:   state_in = ats_pkg::ST_DIVX;
         ats_pkg::ST_DIVX: begin
            if (div_done) begin
               state_in = ats_pkg::ST_MULY;
            end
         end
         ats_pkg::ST_MULY:     state_in = ats_pkg::ST_YSTART;
         ats_pkg::ST_YSTART:   state_in = ats_pkg::ST_DIVY;
         ats_pkg::ST_DIVY: begin
            if (div_done) begin
               state_in = ats_pkg::ST_EMIT;
            end
         end
         ats_pkg::ST_EMIT: begin
            if (idx_ff == '0) begin
               state_in = ats_pkg::ST_PT_RD;
            end else if (out_free) begin
               state_in = pt_last ? ats_pkg::ST_LOAD : ats_pkg::ST_PT_RD;
            end
         end
         default: state_in = ats_pkg::ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in       = cnt_ff;
      ser_cnt_in   = ser_cnt_ff;
      idx_in       = idx_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      pw_in        = pw_ff;
      ph_in        = ph_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      dv_in        = dv_ff;
      qx_in        = qx_ff;
      prod_in      = prod_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (ats_pkg::csr_index_type'(csr_index))
            ats_pkg::CSR_ORIGIN_X:    ox_in = csr_wdata;
            ats_pkg::CSR_ORIGIN_Y:    oy_in = csr_wdata;
            ats_pkg::CSR_PLOT_WIDTH:  pw_in = csr_wdata;
            ats_pkg::CSR_PLOT_HEIGHT: ph_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ats_pkg::ST_LOAD: begin
            if (load_beat) begin
               if (req_data.end_of_series) begin
                  cnt_in     = '0;
                  ser_cnt_in = ser_cnt_new;
                  idx_in     = '0;
               end else begin
                  cnt_in = ser_cnt_new;
               end
            end
         end
         ats_pkg::ST_SCAN_CMP: begin
            if (idx_ff == '0) begin
               min_in = rd_ext;
               max_in = rd_ext;
            end else begin
               if (rd_ext < min_ff) min_in = rd_ext;
               if (rd_ext > max_ff) max_in = rd_ext;
            end
            idx_in = scan_last ? '0 : idx_ff + AW'(1);
         end
         ats_pkg::ST_ADJ: begin
            // flat series: open the range to middle -/+ 1.0
            if (min_ff == max_ff) begin
               min_in = min_ff - EW'(ats_pkg::WIDEN_LSB);
               max_in = max_ff + EW'(ats_pkg::WIDEN_LSB);
            end
         end
         ats_pkg::ST_PT_SUB: begin
            dv_in = rd_ext - min_ff;
         end
         ats_pkg::ST_MULY: begin
            // divider has settled on the x quotient by now
            qx_in   = div_quot;
            prod_in = y_prod;
         end
         ats_pkg::ST_EMIT: begin
            if (idx_ff == '0) begin
               prev_x_in = pt_x;
               prev_y_in = pt_y;
               idx_in    = idx_ff + AW'(1);
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.x_start         = prev_x_ff;
               rsp_data_in.y_start         = prev_y_ff;
               rsp_data_in.x_end           = pt_x;
               rsp_data_in.y_end           = pt_y;
               rsp_data_in.final_segment   = pt_last;
               prev_x_in                   = pt_x;
               prev_y_in                   = pt_y;
               idx_in                      = pt_last ? '0 : idx_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ats_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ser_cnt_ff   <= '0;
         idx_ff       <= '0;
         ox_ff        <= FW'(0);
         oy_ff        <= FW'(0);
         pw_ff        <= FW'(100);
         ph_ff        <= FW'(50);
         min_ff       <= '0;
         max_ff       <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ser_cnt_ff   <= ser_cnt_in;
         idx_ff       <= idx_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         pw_ff        <= pw_in;
         ph_ff        <= ph_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff       <= dv_in;
      qx_ff       <= qx_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ats_pkg::ST_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fill count never runs past the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   // divider finishes only while the sequencer waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ats_pkg::ST_DIVX || state_ff == ats_pkg::ST_DIVY))
      else $error("divider done outside a divide step");

   // mapping always sees a nonempty range and a valid point index
   a_map_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ats_pkg::ST_PT_RD) |->
         (min_ff < max_ff) && (ser_cnt_ff >= CW'(2)) && (CW'(idx_ff) < ser_cnt_ff))
      else $error("point mapped with bad range or index");

   // a new segment beat comes only from the emit step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ats_pkg::ST_EMIT)
      else $error("segment beat raised outside emit");

endmodule

>>> bench/autoscaled_trace_segments_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoscaled_trace_segments_top_tb: self-checking bench for the trace plotter
// Streams sample series through the req channel and predicts the line
// segments of each series. Every rsp beat is checked field by field against
// the oldest predicted segment. Both sides idle at random, and the plot
// registers are rewritten between phases.
// ----------------------------------------------------------------------------
module autoscaled_trace_segments_top_tb;

   localparam int SAMPLE_W  = ats_pkg::SAMPLE_W;
   localparam int CFG_W     = ats_pkg::CFG_W;
   localparam int COORD_W   = ats_pkg::COORD_W;
   localparam int CSR_IDX_W = ats_pkg::CSR_IDX_W;
   localparam int WIDEN_LSB = ats_pkg::WIDEN_LSB;

   localparam int CAPACITY       = 64;
   localparam int RANDOM_ITEMS   = 280;
   localparam int PHASE_ITEMS    = 45;
   localparam int SETTLE_CYCLES  = 200;   // full-store scan plus one point, with margin
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either channel

   // -------------------------------------------------------------------------
   // Segment prediction and checking
   // -------------------------------------------------------------------------
   class segment_scoreboard;
      logic [CFG_W-1:0]   org_x, org_y, span_x, span_y;
      int                 level[CAPACITY];
      int                 loaded;
      logic [COORD_W-1:0] last_x, last_y;
      ats_pkg::rsp_type   segments_due[$];
      int                 fails;

      function new();
         org_x  = '0;
         org_y  = '0;
         span_x = 12'd100;
         span_y = 12'd50;
         loaded = 0;
         last_x = '0;
         last_y = '0;
         fails  = 0;
      endfunction

      function void set_reg(ats_pkg::csr_index_type idx, logic [CFG_W-1:0] val);
         case (idx)
            ats_pkg::CSR_ORIGIN_X:    org_x  = val;
            ats_pkg::CSR_ORIGIN_Y:    org_y  = val;
            ats_pkg::CSR_PLOT_WIDTH:  span_x = val;
            ats_pkg::CSR_PLOT_HEIGHT: span_y = val;
            default: ;
         endcase
      endfunction

      // Store the sample; on the end mark, scale the series and queue segments.
      function void take_sample(ats_pkg::req_type beat);
         int          cnt, lo, hi;
         longint      num, den, q, t;
         logic [COORD_W-1:0] px, py;
         ats_pkg::rsp_type seg;
         if (loaded < CAPACITY) begin
            level[loaded] = {{8{beat.sample[SAMPLE_W-1]}}, beat.sample};
            loaded++;
         end
         if (!beat.end_of_series)
            return;
         cnt = loaded;
         loaded = 0;
         if (cnt < 2)
            return;
         lo = level[0];
         hi = level[0];
         for (int i = 1; i < cnt; i++) begin
            if (level[i] < lo) lo = level[i];
            if (level[i] > hi) hi = level[i];
         end
         // flat series: open the range to +-1.0 around the value
         if (lo == hi) begin
            lo -= WIDEN_LSB;
            hi += WIDEN_LSB;
         end
         den = longint'(hi) - longint'(lo);
         for (int i = 0; i < cnt; i++) begin
            num = (longint'(level[i]) - longint'(lo)) * longint'(span_y);
            q   = (2 * num + den) / (2 * den);   // round half up
            t   = longint'(i) * longint'(span_x) / longint'(cnt) + longint'(org_x);
            px  = t[COORD_W-1:0];
            t   = longint'(span_y) - q + longint'(org_y);
            py  = t[COORD_W-1:0];
            if (i > 0) begin
               seg.x_start       = last_x;
               seg.y_start       = last_y;
               seg.x_end         = px;
               seg.y_end         = py;
               seg.final_segment = (i == cnt - 1);
               segments_due.push_back(seg);
            end
            last_x = px;
            last_y = py;
         end
      endfunction

      function void match_field(string label, logic [COORD_W-1:0] want,
                                logic [COORD_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", label, want, got);
            fails++;
         end
      endfunction

      function void check_segment(ats_pkg::rsp_type got);
         ats_pkg::rsp_type want;
         if (segments_due.size() == 0) begin
            $error("segment beat with nothing predicted: %p", got);
            fails++;
            return;
         end
         want = segments_due.pop_front();
         match_field("x_start", want.x_start, got.x_start);
         match_field("y_start", want.y_start, got.y_start);
         match_field("x_end", want.x_end, got.x_end);
         match_field("y_end", want.y_end, got.y_end);
         match_field("final_segment", COORD_W'(want.final_segment),
                     COORD_W'(got.final_segment));
      endfunction

      function int pending();
         return segments_due.size();
      endfunction

      function void close_out();
         if (segments_due.size() != 0) begin
            $error("%0d predicted segments never arrived", segments_due.size());
            fails++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ats_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ats_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   bit               no_idle = 1'b0;   // phase without gaps on either side
   int               idle_cycles = 0;

   segment_scoreboard sb = new();

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   autoscaled_trace_segments_top #(
      .MAX_SAMPLES(CAPACITY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pause_cycles();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Register value biased toward the extremes.
   function automatic logic [CFG_W-1:0] pick_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return '0;
      if (r < 40) return 12'd4095;
      if (r < 50) return 12'd1;
      return CFG_W'($urandom_range(0, 4095));
   endfunction

   // Series length: mostly short, some single, a few up to and past capacity.
   function automatic int series_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 1;
      if (r < 75) return $urandom_range(2, 8);
      if (r < 92) return $urandom_range(9, 24);
      if (r < 97) return $urandom_range(25, CAPACITY);
      return $urandom_range(CAPACITY + 1, CAPACITY + 6);
   endfunction

   function automatic ats_pkg::req_type make_beat(int value, bit last);
      ats_pkg::req_type beat;
      beat.sample        = value[SAMPLE_W-1:0];
      beat.end_of_series = last;
      return beat;
   endfunction

   // One req beat. valid stays high after acceptance so a back-to-back beat
   // never lowers and raises it in the same step; the task drops it on pauses.
   task automatic send_beat(input ats_pkg::req_type beat);
      int gap;
      gap = pause_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_sample(beat);
   endtask

   // Random content: full range, narrow band, flat, extremes, tie-prone band.
   task automatic send_series(input int len, input int kind);
      int base, v, r;
      base = $urandom();
      for (int k = 0; k < len; k++) begin
         case (kind)
            0: v = $urandom();
            1: v = base + $urandom_range(0, 15);
            2: v = base;
            3: begin
               r = $urandom_range(0, 3);
               v = (r == 0) ? -8388608 : (r == 1) ? 8388607 : (r == 2) ? 0 : $urandom();
            end
            default: v = base + $urandom_range(0, 3);
         endcase
         send_beat(make_beat(v, k == len - 1));
      end
   endtask

   // Hold the sender until every predicted segment is in.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input ats_pkg::csr_index_type idx,
                            input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // Registers change only with the block idle: drained and settled.
   task automatic write_setup(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
                              input logic [CFG_W-1:0] pw, input logic [CFG_W-1:0] ph);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(ats_pkg::CSR_ORIGIN_X, ox);
      write_reg(ats_pkg::CSR_ORIGIN_Y, oy);
      write_reg(ats_pkg::CSR_PLOT_WIDTH, pw);
      write_reg(ats_pkg::CSR_PLOT_HEIGHT, ph);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stall stretches, and open runs, some of them long
   // -------------------------------------------------------------------------
   initial begin : rsp_pacing
      int n;
      forever begin
         n = pause_cycles();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < 85)
            repeat ($urandom_range(1, 6)) @(posedge clock);
         else
            repeat ($urandom_range(30, 120)) @(posedge clock);
      end
   end

   // Every accepted rsp beat is checked with pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_segment(rsp_data);
   end

   // Watchdog: no beat on either channel for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int phase, phase_items, random_items, len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, on the reset register values.
      send_beat(make_beat(1000, 1'b1));           // single sample: no segment
      send_beat(make_beat(8388607, 1'b0));        // full-scale swing
      send_beat(make_beat(-8388608, 1'b1));
      for (int k = 0; k < 3; k++)                 // flat series gets widened
         send_beat(make_beat(5, k == 2));
      for (int k = 0; k < 2; k++)                 // flat at the bottom, widens below range
         send_beat(make_beat(-8388608, k == 1));
      for (int k = 0; k < 2; k++)                 // flat at the top
         send_beat(make_beat(8388607, k == 1));
      for (int k = 0; k < 5; k++)                 // 0..4 LSB: ties round up
         send_beat(make_beat(k, k == 4));

      // Random phases. The first ones pin the register extremes, including
      // zero width and zero height; later ones draw biased values.
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: write_setup(12'd4095, 12'd4095, 12'd4095, 12'd4095);
            1: write_setup('0, '0, '0, '0);
            2: write_setup('0, '0, 12'd1, 12'd4095);
            3: write_setup(12'd4095, '0, 12'd4095, 12'd1);
            default: write_setup(pick_reg(), pick_reg(), pick_reg(), pick_reg());
         endcase
         no_idle = (phase == 3) || ($urandom_range(0, 4) == 0);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            // open with a series that overruns the store, end mark on a dropped beat
            len = (phase == 0 && phase_items == 0) ? CAPACITY + 3 : series_len();
            send_series(len, $urandom_range(0, 4));
            phase_items  += (len > CAPACITY) ? CAPACITY : len;
            random_items += (len > CAPACITY) ? CAPACITY : len;
            if ((phase == 1 && phase_items == len) || $urandom_range(0, 6) == 0)
               drain();
         end
         phase++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.fails == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
